### rtl/core/sha256c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256c_pkg
// Shared types, constants and round functions of the SHA-256 block
// compressor.
// ----------------------------------------------------------------------------
package sha256c_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned IDX_W   = $clog2(HASH_WORDS);
  localparam int unsigned WCNT_W  = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W = $clog2(ROUNDS);

  localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One queued message word, tagged by the front end.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              start;  // reload the initial hash before this word
    logic              last;   // sixteenth word of a block
  } entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } back_st_e;

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

### rtl/core/sha256c_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256c_front
// Counts accepted words within the block and tags each one with its
// start and end-of-block flags.
// ----------------------------------------------------------------------------
module sha256c_front
  import sha256c_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [WORD_W-1:0] message_word_i,
  input  logic              start_message_i,
  output entry_t            entry_o
);

  logic [WCNT_W-1:0] cnt_q, cnt_d;
  logic [WCNT_W-1:0] pos;

  // A start flag drops any partial block: this word becomes word zero.
  assign pos = start_message_i ? '0 : cnt_q;
  assign cnt_d = accept_i ? pos + 1'b1 : cnt_q;

  assign entry_o.word  = message_word_i;
  assign entry_o.start = start_message_i;
  assign entry_o.last  = (pos == WCNT_W'(BLOCK_WORDS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sha256c_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256c_fifo
// Short word queue between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha256c_fifo
  import sha256c_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sha256c_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256c_back
// Compression engine: shifts words into the schedule window, runs one
// round per cycle, folds into the chaining value and streams it out.
// ----------------------------------------------------------------------------
module sha256c_back
  import sha256c_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              entry_valid_i,
  input  entry_t            entry_i,
  output logic              pop_o,
  output logic              digest_valid_o,
  output logic [WORD_W-1:0] digest_word_o,
  output logic [IDX_W-1:0]  digest_index_o,
  output logic              last_word_o
);

  back_st_e           state_q, state_d;
  logic [ROUND_W-1:0] rnd_q, rnd_d;
  logic [IDX_W-1:0]   idx_q, idx_d;

  logic [WORD_W-1:0]  cv_q    [HASH_WORDS];
  logic [WORD_W-1:0]  v_q     [HASH_WORDS];
  logic [WORD_W-1:0]  sched_q [BLOCK_WORDS];

  logic               do_round, do_final, do_load_vars;
  logic [WORD_W-1:0]  t1, t2, ch, maj, new_w;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (pop_o && entry_i.last) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == ROUND_W'(ROUNDS - 1)) state_d = ST_FINAL;
      ST_FINAL: state_d = ST_EMIT;
      ST_EMIT:  if (idx_q == IDX_W'(HASH_WORDS - 1)) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // Outputs and strobes.
  always_comb begin
    pop_o          = 1'b0;
    do_round       = 1'b0;
    do_final       = 1'b0;
    digest_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD:  pop_o = entry_valid_i;
      ST_ROUND: do_round = 1'b1;
      ST_FINAL: do_final = 1'b1;
      // Keep filling the window while the digest drains, but hold off a
      // start (it would overwrite the chaining value) and a block end.
      ST_EMIT: begin
        digest_valid_o = 1'b1;
        pop_o = entry_valid_i && !entry_i.start && !entry_i.last;
      end
      default: pop_o = 1'b0;
    endcase
  end

  assign do_load_vars = pop_o && entry_i.last;

  assign rnd_d = do_round ? rnd_q + 1'b1 : rnd_q;
  assign idx_d = digest_valid_o ? idx_q + 1'b1 : idx_q;

  assign digest_word_o  = cv_q[idx_q];
  assign digest_index_o = idx_q;
  assign last_word_o    = digest_valid_o && (idx_q == IDX_W'(HASH_WORDS - 1));

  // Round datapath: v_q holds a..h, sched_q[0] is W[t].
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[rnd_q] + sched_q[0];
  assign t2    = big_sigma0(v_q[0]) + maj;
  assign new_w = sched_q[0] + small_sigma0(sched_q[1]) + sched_q[9]
               + small_sigma1(sched_q[14]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      rnd_q   <= '0;
      idx_q   <= '0;
      for (int i = 0; i < HASH_WORDS; i++) begin
        cv_q[i] <= INIT_HASH[i];
      end
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      if (pop_o && entry_i.start) begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          cv_q[i] <= INIT_HASH[i];
        end
      end else if (do_final) begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          cv_q[i] <= cv_q[i] + v_q[i];
        end
      end
    end
  end

  // Schedule window and working variables carry no reset.
  always_ff @(posedge clk_i) begin
    if (pop_o || do_round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[BLOCK_WORDS-1] <= pop_o ? entry_i.word : new_w;
    end
    if (do_load_vars) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        v_q[i] <= cv_q[i];
      end
    end else if (do_round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sha256_block_compressor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_block_compressor_top
// SHA-256 compression of 16-word blocks into an eight-word chaining value.
// ----------------------------------------------------------------------------
// A word transaction is taken on a clock edge with start high and busy low;
// message_word_i is one big-endian 32-bit word and start_message_i marks the
// first word of a message, which reloads the initial hash and restarts the
// block. Accepted words enter a small queue (QueueDepth entries), so busy
// only rises once that queue is full. After the sixteenth word of a block
// the engine runs 64 rounds at one round per cycle, adds the result into
// the chaining value, and then presents H0..H7 back to back with
// digest_valid_o high and last_word_o on H7. The receiver cannot stall:
// each digest word is valid for exactly one cycle and must be captured
// then. With words fed back to back, throughput is set by the single
// shared round unit; up to eight of the next block's words load while the
// digest drains. A start word that opens a new message waits until the
// digest has drained before it may reload the chaining value.
// ----------------------------------------------------------------------------
module sha256_block_compressor_top
  import sha256c_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] message_word_i,
  input  logic              start_message_i,
  output logic              digest_valid_o,
  output logic [WORD_W-1:0] digest_word_o,
  output logic [IDX_W-1:0]  digest_index_o,
  output logic              last_word_o
);

  logic   accept;
  logic   q_full, q_valid, q_pop;
  entry_t f_entry, q_entry;

  // Accept a transaction whenever the queue has room.
  assign busy   = q_full;
  assign accept = start && !busy;

  sha256c_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .message_word_i  (message_word_i),
    .start_message_i (start_message_i),
    .entry_o         (f_entry)
  );

  sha256c_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  sha256c_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_valid_i  (q_valid),
    .entry_i        (q_entry),
    .pop_o          (q_pop),
    .digest_valid_o (digest_valid_o),
    .digest_word_o  (digest_word_o),
    .digest_index_o (digest_index_o),
    .last_word_o    (last_word_o)
  );

  // Digest words stream without gaps until the last one.
  a_digest_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o && !last_word_o |=> digest_valid_o)
    else $error("digest burst broken before H7");

  // Every burst opens with H0.
  a_burst_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(digest_valid_o) |-> digest_index_o == '0)
    else $error("digest burst does not start at H0");

  // Never reload the chaining value while it is being read out.
  a_no_reload_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && q_entry.start |-> !digest_valid_o)
    else $error("start word consumed during digest output");

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 block compressor testbench
// Feeds message words through the start/busy command port and checks every
// digest word against a built-in SHA-256 compression predictor: a directed
// restart-in-mid-block case first, then random multi-block messages with
// random sender gaps, and a back-to-back burst at the end.
// ----------------------------------------------------------------------------
module testbench;

  import sha256c_pkg::WORD_W;
  import sha256c_pkg::IDX_W;

  localparam int unsigned NUM_HASH     = 8;
  localparam int unsigned NUM_BLK      = 16;
  localparam int unsigned NUM_RND      = 64;
  // The longest correct stretch without a transaction is the rounds and the
  // fold of one block, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_MAX = 1000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_WORDS = 80;

  localparam logic [31:0] HASH_IV [NUM_HASH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [NUM_RND] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One expected digest word, in the order the block emits them.
  typedef struct {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  index;
    logic              last;
  } digest_rec_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic [WORD_W-1:0] msg_word     = '0;
  logic              msg_first    = 1'b0;
  logic              digest_valid;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  digest_index;
  logic              digest_last;

  // Predictor state: chaining value, partial block and its fill level.
  logic [31:0] hash_state [NUM_HASH];
  logic [31:0] block_buf  [NUM_BLK];
  int unsigned words_held;

  digest_rec_t expected_digest [$];
  int unsigned err_count    = 0;
  int unsigned stall_cycles = 0;
  int unsigned words_sent   = 0;

  sha256_block_compressor_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .message_word_i  (msg_word),
    .start_message_i (msg_first),
    .digest_valid_o  (digest_valid),
    .digest_word_o   (digest_word),
    .digest_index_o  (digest_index),
    .last_word_o     (digest_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run 64 rounds over the gathered block and fold into the chaining value.
  function automatic void compress_block();
    logic [31:0] sched [NUM_RND];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    int unsigned t;
    for (t = 0; t < NUM_BLK; t++) sched[t] = block_buf[t];
    for (t = NUM_BLK; t < NUM_RND; t++) begin
      s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (t = 0; t < NUM_RND; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[t] + sched[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  // Take one accepted word; queue H0..H7 when it completes a block.
  function automatic void absorb_word(input logic [31:0] w, input logic first);
    digest_rec_t rec;
    if (first) begin
      hash_state = HASH_IV;
      words_held = 0;
    end
    block_buf[words_held] = w;
    words_held++;
    if (words_held == NUM_BLK) begin
      words_held = 0;
      compress_block();
      for (int unsigned i = 0; i < NUM_HASH; i++) begin
        rec.word  = hash_state[i];
        rec.index = IDX_W'(i);
        rec.last  = (i == NUM_HASH - 1);
        expected_digest.push_back(rec);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Bias toward the all-zero and all-one words; otherwise any 32-bit value.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Drive one word transaction and hold it until the block takes it. Start is
  // left high afterwards so back-to-back words see no bubble; an idle burst
  // drops it first.
  task automatic send_word(input logic [31:0] w, input logic first,
                           input bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start     <= 1'b1;
    msg_word  <= w;
    msg_first <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_word(w, first);
    words_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Open a message with extreme words, then restart it in mid-block with the
  // padded "abc" block: the partial block must be dropped and the IV reloaded.
  task automatic test_restart_mid_block();
    send_word(32'hffff_ffff, 1'b1, 1'b1);
    send_word(32'h0000_0000, 1'b0, 1'b1);
    send_word(32'h8000_0001, 1'b0, 1'b1);
    send_word(32'h6162_6380, 1'b1, 1'b1);
    for (int i = 1; i < 15; i++) send_word(32'h0, 1'b0, 1'b1);
    send_word(32'h0000_0018, 1'b0, 1'b1);
  endtask

  // Mostly well-formed messages of one to three chained blocks with random
  // content; some are cut short and abandoned, and a few open without the
  // start flag so they keep chaining on whatever came before.
  task automatic test_random_messages();
    int unsigned n_words;
    bit          opens;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 5) == 0) n_words = $urandom_range(1, 15);
      else n_words = NUM_BLK * $urandom_range(1, 3);
      opens = ($urandom_range(0, 7) != 0);
      for (int unsigned i = 0; i < n_words; i++) begin
        send_word(rand_word(), opens && (i == 0), 1'b1);
      end
    end
  endtask

  // Two chained blocks with the sender never idle.
  task automatic test_back_to_back();
    for (int unsigned i = 0; i < 2 * NUM_BLK; i++) begin
      send_word(rand_word(), i == 0, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Digest checker: every strobe must match the oldest expected word
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    digest_rec_t want;
    if (rst_n && digest_valid) begin
      if (expected_digest.size() == 0) begin
        flag_error($sformatf("unexpected digest word: word=%h index=%0d last=%b",
                             digest_word, digest_index, digest_last));
      end else begin
        want = expected_digest.pop_front();
        if (digest_word !== want.word || digest_index !== want.index ||
            digest_last !== want.last) begin
          flag_error($sformatf(
            "digest mismatch: expected word=%h index=%0d last=%b, got word=%h index=%0d last=%b",
            want.word, want.index, want.last, digest_word, digest_index, digest_last));
        end
      end
    end
  end

  // Abort when neither side completes a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || digest_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_MAX) begin
      $display("sha256_block_compressor_top test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    hash_state = HASH_IV;
    words_held = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_restart_mid_block();
    test_random_messages();
    test_back_to_back();
    start <= 1'b0;

    // Drain outstanding digests, then watch a while for stray strobes.
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_digest.size() == 0) begin
      $display("sha256_block_compressor_top test passed");
    end else begin
      $display("sha256_block_compressor_top test failed");
    end
    $finish;
  end

endmodule
